/* hdl/eig_pkg.sv */
// Shared constants, types and step functions for the 2x2 symmetric eigen solver.
package eig_pkg;

    localparam int DATA_W    = 32;
    localparam int IN_W      = 31;
    localparam int VEC_FRAC  = 14;
    localparam int VEC_W     = VEC_FRAC + 2;
    localparam int RAD_W     = 66;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SQ_STAGES = ROOT_W;
    localparam int REM_W     = ROOT_W + 3;
    localparam int AXIS_W    = DATA_W - 1;
    localparam int RAW_W     = DATA_W + 2;
    localparam int NORM_W    = DATA_W;
    localparam int QUO_W     = VEC_FRAC + 1;
    localparam int NUM_W     = AXIS_W + QUO_W;
    localparam int DIV_STAGES = QUO_W;
    localparam int LATENCY   = 2 * SQ_STAGES + DIV_STAGES + 9;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [VEC_W-1:0]  VEC_ONE  = VEC_W'(1) << VEC_FRAC;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [NORM_W-1:0] rem;
        logic              qbit;
    } dv_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] d;
        logic [DATA_W-1:0]        axy;
        logic                     xyneg;
        logic [DATA_W-1:0]        s;
        logic                     iso;
    } side1_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] lmax;
        logic signed [DATA_W-1:0] lmin;
        logic [AXIS_W-1:0]        ax;
        logic [AXIS_W-1:0]        ay;
        logic                     nx;
        logic                     ny;
        logic                     iso;
    } side2_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] lmax;
        logic signed [DATA_W-1:0] lmin;
        logic                     nx;
        logic                     ny;
        logic                     iso;
    } side3_t;

    function automatic sq_t sqrt_step(input logic [REM_W-1:0] rem,
                                      input logic [ROOT_W-1:0] root,
                                      input logic [1:0] pair);
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        sq_t              res;
        cur   = {rem[REM_W-3:0], pair};
        trial = {1'b0, root, 2'b01};
        if (cur >= trial)
        begin
            res.rem  = cur - trial;
            res.root = {root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            res.rem  = cur;
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    function automatic dv_t div_step(input logic [NORM_W-1:0] rem,
                                     input logic nbit,
                                     input logic [NORM_W-1:0] den);
        logic [NORM_W:0] cur;
        dv_t             res;
        cur = {rem, nbit};
        if (cur >= {1'b0, den})
        begin
            res.rem  = NORM_W'(cur - {1'b0, den});
            res.qbit = 1'b1;
        end
        else
        begin
            res.rem  = cur[NORM_W-1:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

/* hdl/eig_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module eig_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [eig_pkg::RAD_W-1:0]  rad,
    output logic                       out_valid,
    output logic [eig_pkg::ROOT_W-1:0] root
);
    import eig_pkg::*;

    logic [SQ_STAGES-1:0] vld_reg;
    logic [REM_W-1:0]     rem_reg  [0:SQ_STAGES-1];
    logic [ROOT_W-1:0]    root_reg [0:SQ_STAGES-1];
    logic [RAD_W-1:0]     rad_reg  [0:SQ_STAGES-1];

    logic [REM_W-1:0]     rem_in  [0:SQ_STAGES-1];
    logic [ROOT_W-1:0]    root_in [0:SQ_STAGES-1];
    logic [RAD_W-1:0]     rad_in  [0:SQ_STAGES-1];
    logic [SQ_STAGES-1:0] vld_in;

    for (genvar g = 0; g < SQ_STAGES; g++)
    begin : g_stage
        sq_t step_next;

        if (g == 0)
        begin : g_first
            assign rem_in[g]  = '0;
            assign root_in[g] = '0;
            assign rad_in[g]  = rad;
            assign vld_in[g]  = in_valid;
        end
        else
        begin : g_rest
            assign rem_in[g]  = rem_reg[g-1];
            assign root_in[g] = root_reg[g-1];
            assign rad_in[g]  = rad_reg[g-1];
            assign vld_in[g]  = vld_reg[g-1];
        end

        always_comb
        begin
            step_next = sqrt_step(rem_in[g], root_in[g],
                                  rad_in[g][2*(SQ_STAGES-1-g)+1 -: 2]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else
            begin
                vld_reg[g] <= vld_in[g];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g]  <= step_next.rem;
            root_reg[g] <= step_next.root;
            rad_reg[g]  <= rad_in[g];
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign root      = root_reg[SQ_STAGES-1];

endmodule

/* hdl/eig_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module eig_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [eig_pkg::NUM_W-1:0] num,
    input  logic [eig_pkg::NORM_W-1:0] den,
    output logic                      out_valid,
    output logic [eig_pkg::QUO_W-1:0] quo
);
    import eig_pkg::*;

    logic [DIV_STAGES-1:0] vld_reg;
    logic [NORM_W-1:0]     rem_reg [0:DIV_STAGES-1];
    logic [QUO_W-1:0]      quo_reg [0:DIV_STAGES-1];
    logic [QUO_W-1:0]      low_reg [0:DIV_STAGES-1];
    logic [NORM_W-1:0]     den_reg [0:DIV_STAGES-1];

    logic [NORM_W-1:0]     rem_in [0:DIV_STAGES-1];
    logic [QUO_W-1:0]      quo_in [0:DIV_STAGES-1];
    logic [QUO_W-1:0]      low_in [0:DIV_STAGES-1];
    logic [NORM_W-1:0]     den_in [0:DIV_STAGES-1];
    logic [DIV_STAGES-1:0] vld_in;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        dv_t step_next;

        if (g == 0)
        begin : g_first
            // quotient fits QUO_W bits, so the high part is already below den
            assign rem_in[g] = NORM_W'(num[NUM_W-1:QUO_W]);
            assign quo_in[g] = '0;
            assign low_in[g] = num[QUO_W-1:0];
            assign den_in[g] = den;
            assign vld_in[g] = in_valid;
        end
        else
        begin : g_rest
            assign rem_in[g] = rem_reg[g-1];
            assign quo_in[g] = quo_reg[g-1];
            assign low_in[g] = low_reg[g-1];
            assign den_in[g] = den_reg[g-1];
            assign vld_in[g] = vld_reg[g-1];
        end

        always_comb
        begin
            step_next = div_step(rem_in[g], low_in[g][QUO_W-1-g], den_in[g]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else
            begin
                vld_reg[g] <= vld_in[g];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g] <= step_next.rem;
            quo_reg[g] <= {quo_in[g][QUO_W-2:0], step_next.qbit};
            low_reg[g] <= low_in[g];
            den_reg[g] <= den_in[g];
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign quo       = quo_reg[DIV_STAGES-1];

endmodule

/* hdl/symmetric_2x2_eigen.sv */
// Top level: closed-form eigenvalues and unit eigenvectors of a 2x2 symmetric tensor.
// Throughput: one tensor per cycle; busy is always low, set by the fully pipelined
// eigenvalue root (33 stages), vector norm root (33 stages) and dividers (15 stages).
// Reset clears only the valid bits; no result is produced for items in flight at reset.
module symmetric_2x2_eigen (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [eig_pkg::IN_W-1:0]          tensor_xx,
    input  logic [eig_pkg::IN_W-1:0]          tensor_yy,
    input  logic signed [eig_pkg::DATA_W-1:0] tensor_xy,
    output logic                              done,
    output logic signed [eig_pkg::DATA_W-1:0] lambda_max,
    output logic signed [eig_pkg::DATA_W-1:0] lambda_min,
    output logic signed [eig_pkg::VEC_W-1:0]  major_vec_x,
    output logic signed [eig_pkg::VEC_W-1:0]  major_vec_y,
    output logic signed [eig_pkg::VEC_W-1:0]  minor_vec_x,
    output logic signed [eig_pkg::VEC_W-1:0]  minor_vec_y
);
    import eig_pkg::*;

    // front end
    logic                v1_reg, v2_reg, v3_reg;
    side1_t              s1_reg, s2_reg, s3_reg, s1_next;
    logic [AXIS_W-1:0]   ad1_reg;
    logic [2*AXIS_W-1:0] ad2_reg;
    logic [2*DATA_W-2:0] b2_reg;
    logic [RAD_W-1:0]    rad1_reg;
    logic [AXIS_W-1:0]   ad_next;
    logic signed [DATA_W:0] d_full;

    assign busy = 1'b0;

    always_comb
    begin
        d_full        = $signed({2'b00, tensor_xx}) - $signed({2'b00, tensor_yy});
        s1_next.d     = d_full[DATA_W-1:0];
        s1_next.xyneg = tensor_xy[DATA_W-1];
        s1_next.axy   = tensor_xy[DATA_W-1] ? DATA_W'(-tensor_xy) : DATA_W'(tensor_xy);
        s1_next.s     = DATA_W'({1'b0, tensor_xx} + {1'b0, tensor_yy});
        s1_next.iso   = (tensor_xy == '0) && (tensor_xx == tensor_yy);
        ad_next       = d_full[DATA_W] ? AXIS_W'(-d_full) : AXIS_W'(d_full);
    end

    // eigenvalue root
    logic                sq1_valid;
    logic [ROOT_W-1:0]   r_root;
    side1_t              dly1_reg [0:SQ_STAGES-1];

    eig_isqrt u_sqrt_eig (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .rad       (rad1_reg),
        .out_valid (sq1_valid),
        .root      (r_root)
    );

    // eigenvalues and raw major vector
    logic                  v4_reg, v5_reg, v6_reg, v7_reg;
    side1_t                sd;
    side2_t                s4_next, s4_reg, s5_next, s5_reg, s6_reg, s7_reg;
    logic [RAW_W-1:0]      ax_next, ay_next, ax4_reg, ay4_reg;
    logic [DATA_W+1:0]     lsum;
    logic signed [DATA_W+2:0] ldiff;
    logic signed [DATA_W+2:0] lhalf;
    logic [RAW_W-1:0]      raw_or;
    logic [AXIS_W-1:0]     ax_sh, ay_sh;
    logic [2*AXIS_W-1:0]   sqx_reg, sqy_reg;
    logic [RAD_W-1:0]      rad2_reg;

    always_comb
    begin
        sd    = dly1_reg[SQ_STAGES-1];
        lsum  = {2'b00, sd.s} + {1'b0, r_root};
        ldiff = $signed({3'b000, sd.s}) - $signed({2'b00, r_root});
        lhalf = ldiff >>> 1;

        s4_next = '0;
        if (lsum[DATA_W+1:1] > {2'b00, DATA_MAX[DATA_W-2:0]})
            s4_next.lmax = DATA_MAX;
        else
            s4_next.lmax = lsum[DATA_W:1];

        if (lhalf > $signed({3'b000, DATA_MAX}))
            s4_next.lmin = DATA_MAX;
        else if (lhalf < $signed({{3{1'b1}}, DATA_MIN}))
            s4_next.lmin = DATA_MIN;
        else
            s4_next.lmin = lhalf[DATA_W-1:0];

        if (!sd.d[DATA_W-1])
        begin
            ax_next    = {2'b00, sd.d} + {1'b0, r_root};
            ay_next    = {1'b0, sd.axy, 1'b0};
            s4_next.nx = 1'b0;
            s4_next.ny = sd.xyneg;
        end
        else
        begin
            ax_next    = {1'b0, sd.axy, 1'b0};
            ay_next    = {1'b0, r_root} - {{2{sd.d[DATA_W-1]}}, sd.d};
            s4_next.nx = sd.xyneg;
            s4_next.ny = 1'b0;
        end
        s4_next.iso = sd.iso;
    end

    always_comb
    begin
        raw_or = ax4_reg | ay4_reg;
        if (raw_or[RAW_W-1])
        begin
            ax_sh = AXIS_W'(ax4_reg >> 3);
            ay_sh = AXIS_W'(ay4_reg >> 3);
        end
        else if (raw_or[RAW_W-2])
        begin
            ax_sh = AXIS_W'(ax4_reg >> 2);
            ay_sh = AXIS_W'(ay4_reg >> 2);
        end
        else if (raw_or[RAW_W-3])
        begin
            ax_sh = AXIS_W'(ax4_reg >> 1);
            ay_sh = AXIS_W'(ay4_reg >> 1);
        end
        else
        begin
            ax_sh = ax4_reg[AXIS_W-1:0];
            ay_sh = ay4_reg[AXIS_W-1:0];
        end
        s5_next    = s4_reg;
        s5_next.ax = ax_sh;
        s5_next.ay = ay_sh;
    end

    // vector norm root
    logic              sq2_valid;
    logic [ROOT_W-1:0] n_root;
    side2_t            dly2_reg [0:SQ_STAGES-1];

    eig_isqrt u_sqrt_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v7_reg),
        .rad       (rad2_reg),
        .out_valid (sq2_valid),
        .root      (n_root)
    );

    // normalization
    logic              v8_reg;
    side2_t            sn;
    logic [NORM_W-1:0] n_next, n8_reg;
    logic [NUM_W-1:0]  numx8_reg, numy8_reg;
    side3_t            s8_reg;
    side3_t            dly3_reg [0:DIV_STAGES-1];
    logic              dvx_valid, dvy_valid;
    logic [QUO_W-1:0]  qx, qy;

    always_comb
    begin
        sn     = dly2_reg[SQ_STAGES-1];
        n_next = (n_root[NORM_W-1:0] == '0) ? NORM_W'(1) : n_root[NORM_W-1:0];
    end

    eig_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v8_reg),
        .num       (numx8_reg),
        .den       (n8_reg),
        .out_valid (dvx_valid),
        .quo       (qx)
    );

    eig_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v8_reg),
        .num       (numy8_reg),
        .den       (n8_reg),
        .out_valid (dvy_valid),
        .quo       (qy)
    );

    // sign rule and output
    side3_t                  so;
    logic signed [VEC_W-1:0] vx, vy, mx_next, my_next;
    logic                    done_reg;
    logic signed [DATA_W-1:0] lmax_reg, lmin_reg;
    logic signed [VEC_W-1:0]  mx_reg, my_reg;

    always_comb
    begin
        so = dly3_reg[DIV_STAGES-1];
        vx = so.nx ? -$signed(VEC_W'(qx)) : $signed(VEC_W'(qx));
        vy = so.ny ? -$signed(VEC_W'(qy)) : $signed(VEC_W'(qy));
        if (so.iso)
        begin
            mx_next = VEC_ONE;
            my_next = '0;
        end
        else if (vx < 0 || (vx == 0 && vy < 0))
        begin
            mx_next = -vx;
            my_next = -vy;
        end
        else
        begin
            mx_next = vx;
            my_next = vy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= sq1_valid;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= sq2_valid;
            done_reg <= dvx_valid && dvy_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= s1_next;
        ad1_reg  <= ad_next;
        s2_reg   <= s1_reg;
        ad2_reg  <= ad1_reg * ad1_reg;
        b2_reg   <= (2*DATA_W-1)'(64'(s1_reg.axy) * 64'(s1_reg.axy));
        s3_reg   <= s2_reg;
        rad1_reg <= {4'b0000, ad2_reg} + {1'b0, b2_reg, 2'b00};

        dly1_reg[0] <= s3_reg;
        for (int i = 1; i < SQ_STAGES; i++)
            dly1_reg[i] <= dly1_reg[i-1];

        s4_reg   <= s4_next;
        ax4_reg  <= ax_next;
        ay4_reg  <= ay_next;
        s5_reg   <= s5_next;
        s6_reg   <= s5_reg;
        sqx_reg  <= s5_reg.ax * s5_reg.ax;
        sqy_reg  <= s5_reg.ay * s5_reg.ay;
        s7_reg   <= s6_reg;
        rad2_reg <= RAD_W'({1'b0, sqx_reg} + {1'b0, sqy_reg});

        dly2_reg[0] <= s7_reg;
        for (int i = 1; i < SQ_STAGES; i++)
            dly2_reg[i] <= dly2_reg[i-1];

        n8_reg      <= n_next;
        numx8_reg   <= {1'b0, sn.ax, {VEC_FRAC{1'b0}}} + NUM_W'(n_next >> 1);
        numy8_reg   <= {1'b0, sn.ay, {VEC_FRAC{1'b0}}} + NUM_W'(n_next >> 1);
        s8_reg.lmax <= sn.lmax;
        s8_reg.lmin <= sn.lmin;
        s8_reg.nx   <= sn.nx;
        s8_reg.ny   <= sn.ny;
        s8_reg.iso  <= sn.iso;

        dly3_reg[0] <= s8_reg;
        for (int i = 1; i < DIV_STAGES; i++)
            dly3_reg[i] <= dly3_reg[i-1];

        lmax_reg <= so.lmax;
        lmin_reg <= so.lmin;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
    end

    assign done        = done_reg;
    assign lambda_max  = lmax_reg;
    assign lambda_min  = lmin_reg;
    assign major_vec_x = mx_reg;
    assign major_vec_y = my_reg;
    assign minor_vec_x = -my_reg;
    assign minor_vec_y = mx_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("transfer result missing after pipeline latency");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> lambda_max >= lambda_min)
        else $error("eigenvalues out of order");

    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (major_vec_x > 0 || (major_vec_x == 0 && major_vec_y >= 0)))
        else $error("major vector sign rule broken");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (major_vec_x <= VEC_ONE && major_vec_y <= VEC_ONE
                  && major_vec_y >= -VEC_ONE))
        else $error("major vector component out of range");

endmodule

/* dv/symmetric_2x2_eigen_tb.sv */
// Testbench for symmetric_2x2_eigen: random and corner tensors checked against a scoreboard.
module symmetric_2x2_eigen_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import eig_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] lmax;
        logic signed [DATA_W-1:0] lmin;
        logic signed [VEC_W-1:0]  mjx;
        logic signed [VEC_W-1:0]  mjy;
        logic signed [VEC_W-1:0]  mnx;
        logic signed [VEC_W-1:0]  mny;
    } eig_t;

    int errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    class eigen_scoreboard;
        eig_t pending[$];

        static function logic [32:0] int_sqrt(input logic [65:0] v);
            logic [68:0] rem;
            logic [68:0] trial;
            logic [32:0] root;
            rem  = '0;
            root = '0;
            for (int i = 32; i >= 0; i--)
            begin
                rem   = {rem[66:0], v[2*i+1 -: 2]};
                trial = {34'd0, root, 2'b01};
                if (rem >= trial)
                begin
                    rem  = rem - trial;
                    root = {root[31:0], 1'b1};
                end
                else
                    root = {root[31:0], 1'b0};
            end
            return root;
        endfunction

        static function longint sat_data(input longint v);
            if (v > longint'(DATA_MAX)) return DATA_MAX;
            if (v < longint'(DATA_MIN)) return DATA_MIN;
            return v;
        endfunction

        static function longint scale_comp(input logic [63:0] mag, input bit neg,
                                          input logic [63:0] n);
            logic [63:0] q;
            q = ((mag << VEC_FRAC) + (n >> 1)) / n;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function void note_tensor(input logic [IN_W-1:0] xx, input logic [IN_W-1:0] yy,
                                  input logic signed [DATA_W-1:0] xy);
            longint d, s, r, t, lmin, mx, my;
            logic [63:0] axy, ad, ax, ay, n;
            logic [65:0] rad;
            bit nx, ny;
            eig_t e;
            axy = xy < 0 ? 64'(-longint'(xy)) : 64'(xy);
            d   = longint'(xx) - longint'(yy);
            s   = longint'(xx) + longint'(yy);
            ad  = d < 0 ? 64'(-d) : 64'(d);
            rad = 66'(ad) * 66'(ad) + 66'(4) * 66'(axy) * 66'(axy);
            r   = longint'(int_sqrt(rad));
            t   = s - r;
            lmin = t / 2;
            if (t < 0 && (t % 2) != 0) lmin--;
            e.lmax = DATA_W'(sat_data((s + r) / 2));
            e.lmin = DATA_W'(sat_data(lmin));
            if (axy == 0 && d == 0)
            begin
                mx = longint'(1) << VEC_FRAC;
                my = 0;
            end
            else
            begin
                if (d >= 0)
                begin
                    ax = 64'(d + r); nx = 0;
                    ay = axy << 1;   ny = xy < 0;
                end
                else
                begin
                    ax = axy << 1;   nx = xy < 0;
                    ay = 64'(r - d); ny = 0;
                end
                while (ax >= 64'h8000_0000 || ay >= 64'h8000_0000)
                begin
                    ax >>= 1;
                    ay >>= 1;
                end
                n = 64'(int_sqrt(66'(ax * ax + ay * ay)));
                if (n == 0) n = 1;
                mx = scale_comp(ax, nx, n);
                my = scale_comp(ay, ny, n);
                if (mx < 0 || (mx == 0 && my < 0))
                begin
                    mx = -mx;
                    my = -my;
                end
            end
            e.mjx = VEC_W'(mx);
            e.mjy = VEC_W'(my);
            e.mnx = VEC_W'(-my);
            e.mny = VEC_W'(mx);
            pending.push_back(e);
        endfunction

        task check_result(input eig_t got);
            eig_t w;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result, lambda_max", got.lmax, 0);
                return;
            end
            w = pending.pop_front();
            if (got.lmax !== w.lmax) report_mismatch("lambda_max", got.lmax, w.lmax);
            if (got.lmin !== w.lmin) report_mismatch("lambda_min", got.lmin, w.lmin);
            if (got.mjx !== w.mjx) report_mismatch("major_vec_x", got.mjx, w.mjx);
            if (got.mjy !== w.mjy) report_mismatch("major_vec_y", got.mjy, w.mjy);
            if (got.mnx !== w.mnx) report_mismatch("minor_vec_x", got.mnx, w.mnx);
            if (got.mny !== w.mny) report_mismatch("minor_vec_y", got.mny, w.mny);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic [IN_W-1:0] tensor_xx = '0;
    logic [IN_W-1:0] tensor_yy = '0;
    logic signed [DATA_W-1:0] tensor_xy = '0;
    logic done;
    logic signed [DATA_W-1:0] lambda_max, lambda_min;
    logic signed [VEC_W-1:0] major_vec_x, major_vec_y, minor_vec_x, minor_vec_y;

    eigen_scoreboard sb = new();
    int cycles = 0;

    always #5 clk = ~clk;

    symmetric_2x2_eigen u_top (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && start && !busy)
            sb.note_tensor(tensor_xx, tensor_yy, tensor_xy);
        if (rst_n && done)
            sb.check_result('{lambda_max, lambda_min, major_vec_x, major_vec_y,
                              minor_vec_x, minor_vec_y});
        if (cycles > 200000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // one transfer, with a random number of idle cycles first
    task automatic send_tensor(input logic [IN_W-1:0] xx, input logic [IN_W-1:0] yy,
                               input logic signed [DATA_W-1:0] xy);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        tensor_xx <= xx;
        tensor_yy <= yy;
        tensor_xy <= xy;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] rand_diag();
        case ($urandom_range(0, 3))
            0: return IN_W'($urandom_range(0, 64));
            1: return IN_W'($urandom_range(0, 1 << 20));
            2: return {1'b1, 30'($urandom)} ;
            default: return IN_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_off();
        case ($urandom_range(0, 3))
            0: return DATA_W'($urandom_range(0, 128)) - 64;
            1: return DATA_W'($urandom_range(0, 1 << 21)) - (1 << 20);
            2: return $urandom_range(0, 1) ? DATA_MAX - $urandom_range(0, 3)
                                            : DATA_MIN + $urandom_range(0, 3);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [IN_W-1:0] v;
        logic [IN_W-1:0] allones;
        allones = '1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_tensor(0, 0, 0);
        send_tensor(4096, 4096, 0);
        send_tensor(allones, allones, 0);
        send_tensor(allones, 0, 0);
        send_tensor(0, allones, 0);
        send_tensor(allones, allones, DATA_MAX);
        send_tensor(allones, allones, DATA_MIN);
        send_tensor(0, 0, DATA_MIN);
        send_tensor(0, 0, DATA_MAX);
        send_tensor(0, 0, -1);
        send_tensor(0, 0, 1);
        send_tensor(allones, 0, DATA_MIN);
        send_tensor(0, allones, DATA_MAX);
        send_tensor(100, 50, -25);
        send_tensor(50, 100, 25);
        send_tensor(1, 0, 0);
        send_tensor(0, 1, 0);
        send_tensor(8192, 4096, -4096);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        for (int i = 0; i < 900; i++)
        begin
            v = rand_diag();
            case ($urandom_range(0, 5))
                0: send_tensor(v, v, rand_off());
                1: send_tensor(v, v, 0);
                2: send_tensor(rand_diag(), rand_diag(), 0);
                default: send_tensor(rand_diag(), rand_diag(), rand_off());
            endcase
        end
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
